### rtl/dfs_pkg.sv
// Shared types and constants for the depth-first cycle finder.
`default_nettype none
package dfs_pkg;
  localparam int VERTICES_DEF = 8;
  localparam int VW = 3;
  localparam int MAX_CYCLES = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_INSERT = 2'd0,
    RES_CYCLE  = 2'd1,
    RES_DONE   = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [1:0]    req_type;
    logic [VW-1:0] from_vertex;
    logic [VW-1:0] to_vertex;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    result_kind;
    logic          accepted;
    logic [VW-1:0] cycle_from;
    logic [VW-1:0] cycle_to;
    logic          last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

### rtl/dfs_fifo.sv
// Small synchronous queue and the generic registered-read RAM used by the walk.
`default_nettype none
module dfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end
endmodule

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/dfs_engine.sv
// Back end: graph store and depth-first walk sequencer.
`default_nettype none
module dfs_engine #(
  parameter int VERTICES = dfs_pkg::VERTICES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire dfs_pkg::cmd_t  cmd,
  output logic                cmd_take,
  output logic                res_valid,
  output dfs_pkg::res_t       res,
  input  wire logic           res_full
);
  import dfs_pkg::*;
  localparam int NV = (VERTICES < 8) ? VERTICES : 8;
  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int CW = $clog2(NV + 1);
  localparam int SW = $clog2(NV + 1);
  localparam int LAW = 2 * IW;
  localparam int LDEPTH = 1 << LAW;

  logic [NV-1:0]  edge_present [NV];
  logic [CW-1:0]  neighbor_count [NV];
  logic [1:0]     visit_mark [NV];
  logic [VW-1:0]  stk_v [NV];
  logic [CW-1:0]  stk_p [NV];
  logic [SW-1:0]  sp;
  logic [3:0]     ncyc;
  state_t         state, state_next;
  res_t           pend, pend_next;

  logic [VW-1:0] tv, uv;
  logic [CW-1:0] tp, up;
  logic [IW-1:0] tvi, wi, ai, bi;
  logic [VW-1:0] w;
  logic a_ok, b_ok, ins_ok;
  logic nl_we;
  logic [LAW-1:0] nl_waddr, nl_raddr;
  logic scan_go, fin_now, ent_ok, hit_now, push_now, hit;
  logic done_valid, cyc_valid;
  res_t cyc;

  // Neighbor lists: row per vertex, registered read of the top frame's next entry.
  dfs_ram #(.WIDTH(VW), .DEPTH(LDEPTH)) u_nlist (
    .clk, .we(nl_we), .waddr(nl_waddr), .wdata(cmd.to_vertex),
    .raddr(nl_raddr), .rdata(w)
  );

  assign tv  = stk_v[IW'(sp - 1'b1)];
  assign tp  = stk_p[IW'(sp - 1'b1)];
  assign uv  = stk_v[IW'(sp - SW'(2))];
  assign up  = stk_p[IW'(sp - SW'(2))];
  assign tvi = IW'(tv);
  assign wi  = IW'(w);
  assign ai  = IW'(cmd.from_vertex);
  assign bi  = IW'(cmd.to_vertex);
  assign a_ok = 32'(cmd.from_vertex) < NV;
  assign b_ok = 32'(cmd.to_vertex) < NV;
  assign ins_ok = a_ok && b_ok
    && !edge_present[ai][bi]
    && (32'(neighbor_count[ai]) < NV);

  assign nl_we    = cmd_take && (cmd.req_type == REQ_INSERT) && ins_ok;
  assign nl_waddr = {ai, IW'(neighbor_count[ai])};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) begin
        if (cmd.req_type == REQ_SEARCH && a_ok) state_next = ST_SCAN;
        else state_next = ST_EMIT;
      end
      ST_SCAN: if (sp == '0) state_next = ST_EMIT;
      ST_EMIT: if (!res_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take   = (state == ST_IDLE) && cmd_valid;
    done_valid = (state == ST_EMIT) && !res_full;
    res_valid  = done_valid || cyc_valid;
    res        = cyc_valid ? cyc : pend;
  end

  always_comb begin
    pend_next = '{RES_DONE, 1'b0, '0, '0, 1'b1};
    if (cmd.req_type == REQ_INSERT) begin
      pend_next.result_kind = RES_INSERT;
      pend_next.accepted = ins_ok;
    end
  end

  // Cycle reports: stall the walk when the result queue is full.
  assign scan_go  = (state == ST_SCAN) && (sp != '0) && !res_full;
  assign fin_now  = (tp == '0) || (32'(tp) > NV);
  assign ent_ok   = !fin_now && (32'(w) < NV);
  assign hit_now  = ent_ok && (visit_mark[wi] == 2'd1);
  assign push_now = ent_ok && (visit_mark[wi] == 2'd0) && (32'(sp) < NV);
  assign hit = scan_go && hit_now;

  // Hold the top frame's next entry on the read port; move it with the walk.
  always_comb begin
    nl_raddr = {tvi, IW'(tp - 1'b1)};
    if (cmd_take) nl_raddr = {ai, IW'(neighbor_count[ai] - 1'b1)};
    else if (scan_go) begin
      if (fin_now || hit_now) nl_raddr = {IW'(uv), IW'(up - 1'b1)};
      else if (push_now) nl_raddr = {wi, IW'(neighbor_count[wi] - 1'b1)};
      else nl_raddr = {tvi, IW'(tp - 2'd2)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp <= '0;
      ncyc <= '0;
      for (int i = 0; i < NV; i++) begin
        edge_present[i] <= '0;
        neighbor_count[i] <= '0;
        visit_mark[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cmd_take) begin
        pend <= pend_next;
        ncyc <= '0;
        case (cmd.req_type)
          REQ_INSERT: if (ins_ok) begin
            edge_present[ai][bi] <= 1'b1;
            neighbor_count[ai] <= neighbor_count[ai] + 1'b1;
          end
          REQ_CLEAR: for (int i = 0; i < NV; i++) visit_mark[i] <= '0;
          REQ_SEARCH: if (a_ok) begin
            visit_mark[ai] <= 2'd1;
            stk_v[0] <= cmd.from_vertex;
            stk_p[0] <= neighbor_count[ai];
            sp <= SW'(1);
          end
          default: ;
        endcase
      end else if (scan_go) begin
        if (fin_now) begin
          visit_mark[tvi] <= 2'd2;
          sp <= sp - 1'b1;
        end else begin
          stk_p[IW'(sp - 1'b1)] <= tp - 1'b1;
          if (hit_now) sp <= sp - 1'b1;
          else if (push_now) begin
            visit_mark[wi] <= 2'd1;
            stk_v[IW'(sp)] <= w;
            stk_p[IW'(sp)] <= neighbor_count[wi];
            sp <= sp + 1'b1;
          end
        end
        if (cyc_valid) ncyc <= ncyc + 1'b1;
      end
    end
  end

  // Cycle report beats go out directly on a hit, up to MAX_CYCLES per search.
  assign cyc = '{RES_CYCLE, 1'b0, tv, w, 1'b0};
  assign cyc_valid = hit && ncyc < 4'(MAX_CYCLES);

  assert property (@(posedge clk) disable iff (rst) (state == ST_SCAN) |-> 32'(sp) <= NV)
    else $error("walk stack overflow");
  assert property (@(posedge clk) disable iff (rst) done_valid |-> !cyc_valid)
    else $error("two result sources at once");
  assert property (@(posedge clk) disable iff (rst) cmd_take |=> !cmd_take)
    else $error("took a second command while busy");
endmodule
`default_nettype wire

### rtl/dfs_back_edge_cycle_finder.sv
// Top level of the depth-first cycle finder.
// Both channels look like queues. Push a request with push while full is
// low: req_type 0 inserts edge from_vertex->to_vertex, 1 clears all visit
// marks, 2 runs a depth-first walk from from_vertex. Results appear while
// empty is low and leave on pop. An insert answers with one beat; a search
// gives up to eight back-edge reports (last low) and then one finished beat.
// A search takes one walk step per adjacency entry scanned plus one per
// vertex finished, at most VERTICES*VERTICES + VERTICES. The walk sequencer
// takes one step per cycle from a registered-read neighbor memory, holding
// while the result queue is full. The walk holds one request at a time.
// A four-entry request queue decouples the front from the walk, and a
// result queue lets the walk run while the receiver is slow; when the
// result queue fills, the walk holds until pop frees space.
// Reset clears the graph, visit marks and both queues.
`default_nettype none
module dfs_back_edge_cycle_finder #(
  parameter int VERTICES = dfs_pkg::VERTICES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] req_type,
  input  wire logic [2:0] from_vertex,
  input  wire logic [2:0] to_vertex,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      result_kind,
  output logic            accepted,
  output logic [2:0]      cycle_from,
  output logic [2:0]      cycle_to,
  output logic            last
);
  import dfs_pkg::*;
  localparam int CMDW = $bits(cmd_t);
  localparam int RESW = $bits(res_t);

  cmd_t cin, cq;
  logic cq_empty, take, rv, rfull;
  res_t rr, ro;
  logic [CMDW-1:0] cq_raw;
  logic [RESW-1:0] ro_raw;

  assign cin = '{req_type, from_vertex, to_vertex};

  dfs_fifo #(.WIDTH(CMDW), .DEPTH(4)) u_cmdq (
    .clk, .rst, .wr(push), .wdata(cin), .full,
    .rd(take), .rdata(cq_raw), .empty(cq_empty)
  );
  assign cq = cq_raw;

  dfs_engine #(.VERTICES(VERTICES)) u_eng (
    .clk, .rst, .cmd_valid(!cq_empty), .cmd(cq), .cmd_take(take),
    .res_valid(rv), .res(rr), .res_full(rfull)
  );

  dfs_fifo #(.WIDTH(RESW), .DEPTH(4)) u_resq (
    .clk, .rst, .wr(rv), .wdata(rr),
    .full(rfull), .rd(pop), .rdata(ro_raw), .empty
  );
  assign ro = ro_raw;
  assign result_kind = ro.result_kind;
  assign accepted = ro.accepted;
  assign cycle_from = ro.cycle_from;
  assign cycle_to = ro.cycle_to;
  assign last = ro.last;
endmodule
`default_nettype wire

### test/tb_dfs_back_edge_cycle_finder.sv
// Testbench for the depth-first cycle finder: directed and random requests checked per beat.
module tb_dfs_back_edge_cycle_finder;
  import dfs_pkg::*;

  localparam int NV = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic       acc;
    logic [2:0] cfrom;
    logic [2:0] cto;
    logic       fin;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] req_type = 2'd0;
  logic [2:0] from_vertex = 3'd0;
  logic [2:0] to_vertex = 3'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] result_kind;
  logic       accepted;
  logic [2:0] cycle_from;
  logic [2:0] cycle_to;
  logic       last;

  dfs_back_edge_cycle_finder dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .from_vertex(from_vertex), .to_vertex(to_vertex), .empty(empty), .pop(pop),
    .result_kind(result_kind), .accepted(accepted), .cycle_from(cycle_from),
    .cycle_to(cycle_to), .last(last)
  );

  always #5 clk = ~clk;

  // graph mirror
  bit       has_edge [NV][NV];
  bit [2:0] adj [NV][NV];
  int       adj_len [NV];
  bit [1:0] mark [NV];
  bit [2:0] stk_v [NV];
  int       stk_p [NV];

  beat_t pending_beats[$];
  int    mismatches = 0;
  int    sent = 0;

  task automatic apply_request(input logic [1:0] rq, input logic [2:0] a,
                               input logic [2:0] b);
    int sp;
    int p;
    int ncyc;
    bit [2:0] v;
    bit [2:0] w;
    beat_t r;
    r = '0;
    r.fin = 1'b1;
    case (rq)
      REQ_INSERT: begin
        r.kind = RES_INSERT;
        if (!has_edge[a][b] && adj_len[a] < NV) begin
          has_edge[a][b] = 1'b1;
          adj[a][3'(adj_len[a])] = b;
          adj_len[a]++;
          r.acc = 1'b1;
        end
      end
      REQ_CLEAR: begin
        r.kind = RES_DONE;
        for (int i = 0; i < NV; i++) mark[i] = 2'd0;
      end
      REQ_SEARCH: begin
        r.kind = RES_DONE;
        ncyc = 0;
        mark[a] = 2'd1;
        stk_v[0] = a;
        stk_p[0] = adj_len[a];
        sp = 1;
        while (sp > 0) begin
          v = stk_v[3'(sp-1)];
          p = stk_p[3'(sp-1)];
          if (p == 0) begin
            mark[v] = 2'd2;
            sp--;
          end else begin
            p--;
            stk_p[3'(sp-1)] = p;
            w = adj[v][3'(p)];
            if (mark[w] == 2'd1) begin
              if (ncyc < MAX_CYCLES) begin
                pending_beats.push_back('{RES_CYCLE, 1'b0, v, w, 1'b0});
                ncyc++;
              end
              sp--;
            end else if (mark[w] == 2'd0 && sp < NV) begin
              mark[w] = 2'd1;
              stk_v[3'(sp)] = w;
              stk_p[3'(sp)] = adj_len[w];
              sp++;
            end
          end
        end
      end
      default: r.kind = RES_DONE;
    endcase
    pending_beats.push_back(r);
  endtask

  // push stays high into the next call; the caller drops it after the last beat
  task automatic send_request(input logic [1:0] rq, input logic [2:0] a,
                              input logic [2:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    from_vertex <= a;
    to_vertex <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_request(rq, a, b);
    sent++;
    @(negedge clk);
  endtask

  // result side: random stalls, check on each accepted beat
  initial begin
    int stall;
    beat_t got;
    beat_t want;
    forever begin
      stall = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) stall = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (rst || empty) @(posedge clk);
      got = '{result_kind, accepted, cycle_from, cycle_to, last};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kind %0d acc %0d from %0d to %0d last %0d,",
                      " got kind %0d acc %0d from %0d to %0d last %0d"},
                     want.kind, want.acc, want.cfrom, want.cto, want.fin,
                     got.kind, got.acc, got.cfrom, got.cto, got.fin);
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_insert_extremes();
    send_request(REQ_INSERT, 3'd0, 3'd7);
    send_request(REQ_INSERT, 3'd0, 3'd7);   // duplicate
    send_request(REQ_INSERT, 3'd7, 3'd0);
    send_request(REQ_INSERT, 3'd7, 3'd7);   // self loop
    send_request(REQ_INSERT, 3'd5, 3'd2);
    send_request(REQ_INSERT, 3'd2, 3'd5);
  endtask

  task automatic test_search_cases();
    send_request(REQ_SEARCH, 3'd0, 3'd7);
    send_request(REQ_SEARCH, 3'd0, 3'd0);   // marks kept from previous walk
    send_request(REQ_SEARCH, 3'd3, 3'd0);   // isolated vertex
    send_request(REQ_CLEAR, 3'd7, 3'd7);
    send_request(REQ_SEARCH, 3'd5, 3'd0);
    send_request(REQ_NONE, 3'd7, 3'd7);
    send_request(REQ_CLEAR, 3'd0, 3'd0);
  endtask

  task automatic test_full_list();
    // fill vertex 1's list, then try one more
    for (int i = 0; i < NV; i++) send_request(REQ_INSERT, 3'd1, 3'(i));
    send_request(REQ_INSERT, 3'd1, 3'd4);
    send_request(REQ_SEARCH, 3'd1, 3'd0);
  endtask

  task automatic test_random();
    int pick;
    for (int n = 0; n < 350; n++) begin
      pick = $urandom_range(0, 19);
      if (n == 175) begin
        // clear the marks midway
        send_request(REQ_CLEAR, 3'($urandom), 3'($urandom));
      end else if (pick < 10)
        send_request(REQ_INSERT, 3'($urandom), 3'($urandom));
      else if (pick < 14)
        send_request(REQ_CLEAR, 3'($urandom), 3'($urandom));
      else if (pick < 19)
        send_request(REQ_SEARCH, 3'($urandom), 3'($urandom));
      else
        send_request(REQ_NONE, 3'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NV; i++) begin
      adj_len[i] = 0;
      mark[i] = 2'd0;
      for (int j = 0; j < NV; j++) has_edge[i][j] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_insert_extremes();
    test_search_cases();
    test_full_list();
    test_random();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

### sim.f
rtl/dfs_pkg.sv
rtl/dfs_fifo.sv
rtl/dfs_engine.sv
rtl/dfs_back_edge_cycle_finder.sv
test/tb_dfs_back_edge_cycle_finder.sv
